[src/alsf_pkg.sv]
package alsf_pkg;

    // Field and datapath widths
    localparam int IN_W      = 24;
    localparam int COEF_W    = 48;
    localparam int SUM2_W    = 64;
    localparam int SUM1_W    = 40;
    localparam int OP_W      = 64;
    localparam int COF_W     = 130;
    localparam int BIG_W     = 224;
    localparam int NUM_COEF  = 6;
    localparam int S_DATA_W  = 4 * IN_W;
    localparam int M_DATA_W  = NUM_COEF * COEF_W;
    localparam int MIN_POINTS = 3;

    // Solve sequencing
    localparam int STEP_COUNT = 33;
    localparam int STEP_W     = 6;
    localparam int DIDX_W     = 3;
    localparam int WGT_SHIFT  = 16;
    localparam int OFS_SHIFT  = 8;
    localparam logic [DIDX_W-1:0] IDX_COEF_C = 3'd2;
    localparam logic [DIDX_W-1:0] IDX_COEF_F = 3'd5;

    typedef logic [1:0] fit_status_t;
    localparam fit_status_t FIT_OK       = 2'd0;
    localparam fit_status_t FIT_FEW      = 2'd1;
    localparam fit_status_t FIT_SINGULAR = 2'd2;
    localparam fit_status_t FIT_OVERFLOW = 2'd3;

    // Multiply operand sources
    typedef logic [4:0] opnd_t;
    localparam opnd_t OP_P   = 5'd0;   // sum sx*sx
    localparam opnd_t OP_Q   = 5'd1;   // sum sx*sy
    localparam opnd_t OP_S   = 5'd2;   // sum sy*sy
    localparam opnd_t OP_U   = 5'd3;   // sum sx
    localparam opnd_t OP_V   = 5'd4;   // sum sy
    localparam opnd_t OP_N   = 5'd5;   // point count
    localparam opnd_t OP_RX0 = 5'd6;
    localparam opnd_t OP_RX1 = 5'd7;
    localparam opnd_t OP_RX2 = 5'd8;
    localparam opnd_t OP_RY0 = 5'd9;
    localparam opnd_t OP_RY1 = 5'd10;
    localparam opnd_t OP_RY2 = 5'd11;
    localparam opnd_t OP_C00 = 5'd12;
    localparam opnd_t OP_C01 = 5'd13;
    localparam opnd_t OP_C02 = 5'd14;
    localparam opnd_t OP_C11 = 5'd15;
    localparam opnd_t OP_C12 = 5'd16;
    localparam opnd_t OP_C22 = 5'd17;

    // Accumulator store targets
    typedef logic [3:0] dest_t;
    localparam dest_t DST_NONE = 4'd0;
    localparam dest_t DST_C00  = 4'd1;
    localparam dest_t DST_C01  = 4'd2;
    localparam dest_t DST_C02  = 4'd3;
    localparam dest_t DST_C11  = 4'd4;
    localparam dest_t DST_C12  = 4'd5;
    localparam dest_t DST_C22  = 4'd6;
    localparam dest_t DST_DET  = 4'd7;
    localparam dest_t DST_NX0  = 4'd8;
    localparam dest_t DST_NX1  = 4'd9;
    localparam dest_t DST_NX2  = 4'd10;
    localparam dest_t DST_NY0  = 4'd11;
    localparam dest_t DST_NY1  = 4'd12;
    localparam dest_t DST_NY2  = 4'd13;

    typedef struct packed {
        opnd_t a_sel;
        opnd_t b_sel;
        logic  sub;
        logic  first;
        dest_t dest;
    } mac_step_t;

    typedef struct packed {
        logic                 acc_en;
        logic                 solve_init;
        logic                 mac_load;
        logic                 mac_run;
        logic                 mac_store;
        mac_step_t            step;
        logic                 div_start;
        logic [DIDX_W-1:0]    div_idx;
        logic                 div_store;
        logic                 finish;
        fit_status_t          fin_status;
    } alsf_cmd_t;

    typedef struct packed {
        logic few;
        logic empty;
        logic mac_last;
        logic det_zero;
        logic div_done;
        logic flagged;
    } alsf_sts_t;

    function automatic mac_step_t mk_step(opnd_t a, opnd_t b, logic sub, logic first,
                                          dest_t dest);
        mac_step_t s;
        s.a_sel = a;
        s.b_sel = b;
        s.sub   = sub;
        s.first = first;
        s.dest  = dest;
        return s;
    endfunction

    // Cofactors of the symmetric normal matrix, then the determinant and the
    // six column-replaced determinants as dot products with cofactor columns.
    function automatic mac_step_t step_rom(logic [STEP_W-1:0] idx);
        mac_step_t s;
        case (idx)
            6'd0:    s = mk_step(OP_S,   OP_N,   1'b0, 1'b1, DST_NONE);
            6'd1:    s = mk_step(OP_V,   OP_V,   1'b1, 1'b0, DST_C00);
            6'd2:    s = mk_step(OP_U,   OP_V,   1'b0, 1'b1, DST_NONE);
            6'd3:    s = mk_step(OP_Q,   OP_N,   1'b1, 1'b0, DST_C01);
            6'd4:    s = mk_step(OP_Q,   OP_V,   1'b0, 1'b1, DST_NONE);
            6'd5:    s = mk_step(OP_S,   OP_U,   1'b1, 1'b0, DST_C02);
            6'd6:    s = mk_step(OP_P,   OP_N,   1'b0, 1'b1, DST_NONE);
            6'd7:    s = mk_step(OP_U,   OP_U,   1'b1, 1'b0, DST_C11);
            6'd8:    s = mk_step(OP_Q,   OP_U,   1'b0, 1'b1, DST_NONE);
            6'd9:    s = mk_step(OP_P,   OP_V,   1'b1, 1'b0, DST_C12);
            6'd10:   s = mk_step(OP_P,   OP_S,   1'b0, 1'b1, DST_NONE);
            6'd11:   s = mk_step(OP_Q,   OP_Q,   1'b1, 1'b0, DST_C22);
            6'd12:   s = mk_step(OP_P,   OP_C00, 1'b0, 1'b1, DST_NONE);
            6'd13:   s = mk_step(OP_Q,   OP_C01, 1'b0, 1'b0, DST_NONE);
            6'd14:   s = mk_step(OP_U,   OP_C02, 1'b0, 1'b0, DST_DET);
            6'd15:   s = mk_step(OP_RX0, OP_C00, 1'b0, 1'b1, DST_NONE);
            6'd16:   s = mk_step(OP_RX1, OP_C01, 1'b0, 1'b0, DST_NONE);
            6'd17:   s = mk_step(OP_RX2, OP_C02, 1'b0, 1'b0, DST_NX0);
            6'd18:   s = mk_step(OP_RX0, OP_C01, 1'b0, 1'b1, DST_NONE);
            6'd19:   s = mk_step(OP_RX1, OP_C11, 1'b0, 1'b0, DST_NONE);
            6'd20:   s = mk_step(OP_RX2, OP_C12, 1'b0, 1'b0, DST_NX1);
            6'd21:   s = mk_step(OP_RX0, OP_C02, 1'b0, 1'b1, DST_NONE);
            6'd22:   s = mk_step(OP_RX1, OP_C12, 1'b0, 1'b0, DST_NONE);
            6'd23:   s = mk_step(OP_RX2, OP_C22, 1'b0, 1'b0, DST_NX2);
            6'd24:   s = mk_step(OP_RY0, OP_C00, 1'b0, 1'b1, DST_NONE);
            6'd25:   s = mk_step(OP_RY1, OP_C01, 1'b0, 1'b0, DST_NONE);
            6'd26:   s = mk_step(OP_RY2, OP_C02, 1'b0, 1'b0, DST_NY0);
            6'd27:   s = mk_step(OP_RY0, OP_C01, 1'b0, 1'b1, DST_NONE);
            6'd28:   s = mk_step(OP_RY1, OP_C11, 1'b0, 1'b0, DST_NONE);
            6'd29:   s = mk_step(OP_RY2, OP_C12, 1'b0, 1'b0, DST_NY1);
            6'd30:   s = mk_step(OP_RY0, OP_C02, 1'b0, 1'b1, DST_NONE);
            6'd31:   s = mk_step(OP_RY1, OP_C12, 1'b0, 1'b0, DST_NONE);
            6'd32:   s = mk_step(OP_RY2, OP_C22, 1'b0, 1'b0, DST_NY2);
            default: s = mk_step(OP_P,   OP_P,   1'b0, 1'b0, DST_NONE);
        endcase
        return s;
    endfunction

endpackage

[src/alsf_div.sv]
module alsf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [alsf_pkg::BIG_W-1:0]  num,
    input  logic [alsf_pkg::BIG_W-1:0]  den,
    output logic                        done,
    output logic [alsf_pkg::COEF_W-1:0] coef,
    output logic                        sat
);
    import alsf_pkg::*;

    localparam int CNT_W = $clog2(BIG_W);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_PREP = 3'd1;
    localparam logic [2:0] D_RUN  = 3'd2;
    localparam logic [2:0] D_DONE = 3'd3;

    logic [2:0]        state_reg, state_next;
    logic [BIG_W-1:0]  an_reg, ad_reg, dvd_reg, dsr_reg, rem_reg;
    logic [COEF_W-1:0] q_reg;
    logic              big_reg, neg_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [BIG_W-1:0]  rem_sh;
    logic [BIG_W:0]    diff;
    logic              ge;
    logic [COEF_W-1:0] limit, mag;

    // Trial subtract of one quotient bit
    assign rem_sh = {rem_reg[BIG_W-2:0], dvd_reg[BIG_W-1]};
    assign diff   = {1'b0, rem_sh} - {1'b0, dsr_reg};
    assign ge     = ~diff[BIG_W];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = D_PREP;
            D_PREP: state_next = D_RUN;
            D_RUN:  if (cnt_reg == CNT_W'(BIG_W - 1)) state_next = D_DONE;
            D_DONE: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Magnitudes, then round-half-up dividend, then restoring division
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            an_reg  <= num[BIG_W-1] ? (~num + BIG_W'(1)) : num;
            ad_reg  <= den[BIG_W-1] ? (~den + BIG_W'(1)) : den;
            neg_reg <= num[BIG_W-1] ^ den[BIG_W-1];
        end
        if (state_reg == D_PREP)
        begin
            dvd_reg <= {an_reg[BIG_W-2:0], 1'b0} + ad_reg;
            dsr_reg <= {ad_reg[BIG_W-2:0], 1'b0};
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
            cnt_reg <= '0;
        end
        if (state_reg == D_RUN)
        begin
            rem_reg <= ge ? diff[BIG_W-1:0] : rem_sh;
            dvd_reg <= {dvd_reg[BIG_W-2:0], 1'b0};
            q_reg   <= {q_reg[COEF_W-2:0], ge};
            big_reg <= big_reg | q_reg[COEF_W-1];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Saturate to the signed 48-bit range and apply the sign
    assign limit = neg_reg ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    assign sat   = big_reg | (q_reg > limit);
    assign mag   = sat ? limit : q_reg;
    assign coef  = neg_reg ? (~mag + COEF_W'(1)) : mag;
    assign done  = (state_reg == D_DONE);

endmodule

[src/alsf_dp.sv]
module alsf_dp #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  alsf_pkg::alsf_cmd_t                cmd,
    input  logic signed [alsf_pkg::IN_W-1:0]   source_x,
    input  logic signed [alsf_pkg::IN_W-1:0]   source_y,
    input  logic signed [alsf_pkg::IN_W-1:0]   target_x,
    input  logic signed [alsf_pkg::IN_W-1:0]   target_y,
    output alsf_pkg::alsf_sts_t                sts,
    output logic [alsf_pkg::M_DATA_W-1:0]      coef_data,
    output alsf_pkg::fit_status_t              fit_status
);
    import alsf_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int BIT_W = $clog2(OP_W);
    localparam int PRD_W = 2 * IN_W;

    // Normal-equation sums
    logic [SUM2_W-1:0] sxsx_reg, sxsy_reg, sysy_reg, txsx_reg, txsy_reg, tysx_reg, tysy_reg;
    logic [SUM1_W-1:0] sx_reg, sy_reg, tx_reg, ty_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg, sat_reg;

    logic signed [PRD_W-1:0] p_sxsx, p_sxsy, p_sysy, p_txsx, p_txsy, p_tysx, p_tysy;
    logic                    room;

    // Solve storage
    logic [COF_W-1:0]  cof_reg [NUM_COEF];
    logic [BIG_W-1:0]  num_reg [NUM_COEF];
    logic [BIG_W-1:0]  det_reg;
    logic [COEF_W-1:0] coef_reg [NUM_COEF];
    fit_status_t       status_reg;

    // Shift-add multiplier
    logic [OP_W-1:0]   mplier_reg;
    logic [BIG_W-1:0]  mcand_reg, acc_reg;
    logic              msub_reg;
    logic [BIT_W-1:0]  bit_reg;

    logic [OP_W-1:0]   src [16];
    logic [OP_W-1:0]   a_op, b_src;
    logic [COF_W-1:0]  b_cof;
    logic [BIG_W-1:0]  b_op, term;
    logic              neg_term;

    logic [BIG_W-1:0]  div_raw, div_num;
    logic              div_done, div_sat;
    logic [COEF_W-1:0] div_coef;

    assign p_sxsx = source_x * source_x;
    assign p_sxsy = source_x * source_y;
    assign p_sysy = source_y * source_y;
    assign p_txsx = target_x * source_x;
    assign p_txsy = target_x * source_y;
    assign p_tysx = target_y * source_x;
    assign p_tysy = target_y * source_y;
    assign room   = (count_reg < CNT_W'(MAX_POINTS));

    // Accumulate one point, drop it when full, clear after each run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sxsx_reg  <= '0;
            sxsy_reg  <= '0;
            sysy_reg  <= '0;
            txsx_reg  <= '0;
            txsy_reg  <= '0;
            tysx_reg  <= '0;
            tysy_reg  <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            tx_reg    <= '0;
            ty_reg    <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.finish)
        begin
            sxsx_reg  <= '0;
            sxsy_reg  <= '0;
            sysy_reg  <= '0;
            txsx_reg  <= '0;
            txsy_reg  <= '0;
            tysx_reg  <= '0;
            tysy_reg  <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            tx_reg    <= '0;
            ty_reg    <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (room)
            begin
                sxsx_reg  <= sxsx_reg + {{(SUM2_W-PRD_W){p_sxsx[PRD_W-1]}}, p_sxsx};
                sxsy_reg  <= sxsy_reg + {{(SUM2_W-PRD_W){p_sxsy[PRD_W-1]}}, p_sxsy};
                sysy_reg  <= sysy_reg + {{(SUM2_W-PRD_W){p_sysy[PRD_W-1]}}, p_sysy};
                txsx_reg  <= txsx_reg + {{(SUM2_W-PRD_W){p_txsx[PRD_W-1]}}, p_txsx};
                txsy_reg  <= txsy_reg + {{(SUM2_W-PRD_W){p_txsy[PRD_W-1]}}, p_txsy};
                tysx_reg  <= tysx_reg + {{(SUM2_W-PRD_W){p_tysx[PRD_W-1]}}, p_tysx};
                tysy_reg  <= tysy_reg + {{(SUM2_W-PRD_W){p_tysy[PRD_W-1]}}, p_tysy};
                sx_reg    <= sx_reg + {{(SUM1_W-IN_W){source_x[IN_W-1]}}, source_x};
                sy_reg    <= sy_reg + {{(SUM1_W-IN_W){source_y[IN_W-1]}}, source_y};
                tx_reg    <= tx_reg + {{(SUM1_W-IN_W){target_x[IN_W-1]}}, target_x};
                ty_reg    <= ty_reg + {{(SUM1_W-IN_W){target_y[IN_W-1]}}, target_y};
                count_reg <= count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Operand sources for the multiplier
    assign src[0]  = sxsx_reg;
    assign src[1]  = sxsy_reg;
    assign src[2]  = sysy_reg;
    assign src[3]  = {{(OP_W-SUM1_W){sx_reg[SUM1_W-1]}}, sx_reg};
    assign src[4]  = {{(OP_W-SUM1_W){sy_reg[SUM1_W-1]}}, sy_reg};
    assign src[5]  = {{(OP_W-CNT_W){1'b0}}, count_reg};
    assign src[6]  = txsx_reg;
    assign src[7]  = txsy_reg;
    assign src[8]  = {{(OP_W-SUM1_W){tx_reg[SUM1_W-1]}}, tx_reg};
    assign src[9]  = tysx_reg;
    assign src[10] = tysy_reg;
    assign src[11] = {{(OP_W-SUM1_W){ty_reg[SUM1_W-1]}}, ty_reg};
    assign src[12] = '0;
    assign src[13] = '0;
    assign src[14] = '0;
    assign src[15] = '0;

    assign a_op  = src[cmd.step.a_sel[3:0]];
    assign b_src = src[cmd.step.b_sel[3:0]];

    // Pick the second operand: a sum or a stored cofactor
    always_comb
    begin
        b_cof = '0;
        case (cmd.step.b_sel) inside
            [OP_C00:OP_C22]:
            begin
                b_cof = cof_reg[3'(cmd.step.b_sel - OP_C00)];
                b_op  = {{(BIG_W-COF_W){b_cof[COF_W-1]}}, b_cof};
            end
            default: b_op = {{(BIG_W-OP_W){b_src[OP_W-1]}}, b_src};
        endcase
    end

    // Top multiplier bit carries negative weight
    assign term     = mplier_reg[0] ? mcand_reg : '0;
    assign neg_term = msub_reg ^ (bit_reg == BIT_W'(OP_W - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.mac_load)
        begin
            mplier_reg <= a_op;
            mcand_reg  <= b_op;
            msub_reg   <= cmd.step.sub;
            bit_reg    <= '0;
            if (cmd.step.first)
            begin
                acc_reg <= '0;
            end
        end
        else if (cmd.mac_run)
        begin
            acc_reg    <= neg_term ? (acc_reg - term) : (acc_reg + term);
            mplier_reg <= {1'b0, mplier_reg[OP_W-1:1]};
            mcand_reg  <= {mcand_reg[BIG_W-2:0], 1'b0};
            bit_reg    <= bit_reg + BIT_W'(1);
        end
    end

    // Store finished sums into cofactor, determinant and numerator registers
    always_ff @(posedge clk)
    begin
        if (cmd.mac_store)
        begin
            case (cmd.step.dest) inside
                [DST_C00:DST_C22]: cof_reg[3'(cmd.step.dest - DST_C00)] <= acc_reg[COF_W-1:0];
                DST_DET:           det_reg <= acc_reg;
                [DST_NX0:DST_NY2]: num_reg[3'(cmd.step.dest - DST_NX0)] <= acc_reg;
                default:           ;
            endcase
        end
    end

    // Scale the numerator into Q.16 for weights, Q.8 inputs give offsets
    assign div_raw = num_reg[cmd.div_idx];
    assign div_num = (cmd.div_idx == IDX_COEF_C || cmd.div_idx == IDX_COEF_F)
                   ? (div_raw << OFS_SHIFT) : (div_raw << WGT_SHIFT);

    alsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (det_reg),
        .done  (div_done),
        .coef  (div_coef),
        .sat   (div_sat)
    );

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.solve_init)
        begin
            for (int k = 0; k < NUM_COEF; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cmd.div_store)
        begin
            coef_reg[cmd.div_idx] <= div_coef;
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (cmd.solve_init)
        begin
            sat_reg <= 1'b0;
        end
        else if (cmd.div_store)
        begin
            sat_reg <= sat_reg | div_sat;
        end
    end

    assign coef_data = {coef_reg[5], coef_reg[4], coef_reg[3],
                        coef_reg[2], coef_reg[1], coef_reg[0]};
    assign fit_status = status_reg;

    assign sts.few      = (count_reg < CNT_W'(MIN_POINTS));
    assign sts.empty    = (count_reg == '0);
    assign sts.mac_last = (bit_reg == BIT_W'(OP_W - 1));
    assign sts.det_zero = (det_reg == '0);
    assign sts.div_done = div_done;
    assign sts.flagged  = sat_reg | ovf_reg;

endmodule

[src/alsf_ctrl.sv]
module alsf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    input  logic                m_tready,
    input  alsf_pkg::alsf_sts_t sts,
    output logic                s_tready,
    output logic                m_tvalid,
    output alsf_pkg::alsf_cmd_t cmd
);
    import alsf_pkg::*;

    localparam logic [3:0] C_IDLE   = 4'd0;
    localparam logic [3:0] C_WAIT   = 4'd1;
    localparam logic [3:0] C_LOAD   = 4'd2;
    localparam logic [3:0] C_RUN    = 4'd3;
    localparam logic [3:0] C_STORE  = 4'd4;
    localparam logic [3:0] C_CHECK  = 4'd5;
    localparam logic [3:0] C_DSTART = 4'd6;
    localparam logic [3:0] C_DWAIT  = 4'd7;
    localparam logic [3:0] C_FIN    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIDX_W-1:0] didx_reg, didx_next;
    fit_status_t       code_reg, code_next;
    logic              m_valid_reg, m_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        didx_next    = didx_reg;
        code_next    = code_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.step     = step_rom(step_reg);
        cmd.div_idx  = didx_reg;

        unique case (state_reg)
            C_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.acc_en = s_tvalid;
                if (s_tvalid && s_tlast) state_next = C_WAIT;
            end
            // Hold the run until the previous result is taken
            C_WAIT:
            begin
                if (!m_valid_reg)
                begin
                    cmd.solve_init = 1'b1;
                    step_next      = '0;
                    if (sts.few)
                    begin
                        code_next  = FIT_FEW;
                        state_next = C_FIN;
                    end
                    else
                    begin
                        state_next = C_LOAD;
                    end
                end
            end
            C_LOAD:
            begin
                cmd.mac_load = 1'b1;
                state_next   = C_RUN;
            end
            C_RUN:
            begin
                cmd.mac_run = 1'b1;
                if (sts.mac_last) state_next = C_STORE;
            end
            C_STORE:
            begin
                cmd.mac_store = 1'b1;
                if (step_reg == STEP_W'(STEP_COUNT - 1))
                begin
                    state_next = C_CHECK;
                end
                else
                begin
                    step_next  = step_reg + STEP_W'(1);
                    state_next = C_LOAD;
                end
            end
            C_CHECK:
            begin
                didx_next = '0;
                if (sts.det_zero)
                begin
                    code_next  = FIT_SINGULAR;
                    state_next = C_FIN;
                end
                else
                begin
                    state_next = C_DSTART;
                end
            end
            C_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = C_DWAIT;
            end
            C_DWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (didx_reg == DIDX_W'(NUM_COEF - 1))
                    begin
                        code_next  = FIT_OK;
                        state_next = C_FIN;
                    end
                    else
                    begin
                        didx_next  = didx_reg + DIDX_W'(1);
                        state_next = C_DSTART;
                    end
                end
            end
            // Publish the result and clear the sums
            C_FIN:
            begin
                cmd.finish     = 1'b1;
                cmd.fin_status = (code_reg == FIT_OK && sts.flagged) ? FIT_OVERFLOW : code_reg;
                m_valid_next   = 1'b1;
                state_next     = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            step_reg    <= '0;
            didx_reg    <= '0;
            code_reg    <= FIT_OK;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            didx_reg    <= didx_next;
            code_reg    <= code_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

[src/affine_least_squares_fit_unit.sv]
// Least-squares 2-D affine fit over a run of control points.
// Slave channel: one transaction per point pair (source x,y and target x,y,
// signed Q16.8); tlast marks the final point of the run. Points are taken
// one per cycle while no run is waiting or being solved; a point arriving with
// MAX_POINTS already counted is dropped and flags overflow.
// Master channel: one transaction per run with six Q32.16 coefficients
// (a..f, with tx = a*sx + b*sy + c, ty = d*sx + e*sy + f) and a status in
// tuser: ok, fewer than three points, singular, or overflow/saturation.
// A full solve makes 33 multiply passes on one shift-add multiplier, then
// six divisions on one restoring divider; a singular matrix ends after the
// multiply passes and a short run skips the solve. The slave channel is
// stalled during the solve. A finished result waits in the output register
// while the next run accumulates; a new solve starts only after it is taken.
// Reset clears all sums, the point count and the output valid.
module affine_least_squares_fit_unit #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // source_x, source_y, target_x, target_y
    input  logic [alsf_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // coef_a, coef_b, coef_c, coef_d, coef_e, coef_f
    output logic [alsf_pkg::M_DATA_W-1:0]    m_tdata,
    // fit_status
    output logic [1:0]                       m_tuser
);
    import alsf_pkg::*;

    alsf_cmd_t cmd;
    alsf_sts_t sts;

    logic signed [IN_W-1:0] source_x, source_y, target_x, target_y;

    assign source_x = s_tdata[IN_W-1:0];
    assign source_y = s_tdata[2*IN_W-1:IN_W];
    assign target_x = s_tdata[3*IN_W-1:2*IN_W];
    assign target_y = s_tdata[4*IN_W-1:3*IN_W];

    alsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .sts      (sts),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    alsf_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .source_x   (source_x),
        .source_y   (source_y),
        .target_x   (target_x),
        .target_y   (target_y),
        .sts        (sts),
        .coef_data  (m_tdata),
        .fit_status (m_tuser)
    );

`ifndef SYNTHESIS
    // A new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |-> !m_tvalid)
        else $error("result published over a pending transaction");

    // Sums are empty right after a result is published
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> sts.empty)
        else $error("accumulators not cleared after run");

    // Division only runs on a nonzero determinant
    assert property (@(posedge clk) disable iff (!rst_n) cmd.div_start |-> !sts.det_zero)
        else $error("division started with zero determinant");
`endif

endmodule

[sim/affine_least_squares_fit_checker.sv]
`timescale 1ns / 1ps

module affine_least_squares_fit_checker
    import alsf_pkg::*;
#(
    parameter int MAX_POINTS = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_DATA_W-1:0]    m_tdata,
    input  logic [1:0]             m_tuser,
    output int                     mismatches,
    output int                     fits_pending
);

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [M_DATA_W-1:0] coefs;
        fit_status_t         status;
    } fit_result_t;

    fit_result_t fit_queue[$];

    // Running normal-equation sums of the current run
    logic signed [63:0] sum_xx, sum_xy, sum_yy, sum_x, sum_y;
    logic signed [63:0] sum_txx, sum_txy, sum_tx, sum_tyx, sum_tyy, sum_ty;
    int unsigned        run_points;
    bit                 points_dropped;

    assign fits_pending = fit_queue.size();

    initial mismatches = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic clear_sums();
        sum_xx = 0; sum_xy = 0; sum_yy = 0; sum_x = 0; sum_y = 0;
        sum_txx = 0; sum_txy = 0; sum_tx = 0; sum_tyx = 0; sum_tyy = 0; sum_ty = 0;
        run_points = 0;
        points_dropped = 0;
    endtask

    function automatic wide_t det3(input wide_t m [9]);
        wide_t t0, t1, t2;
        t0 = m[0] * (m[4] * m[8] - m[5] * m[7]);
        t1 = m[1] * (m[3] * m[8] - m[5] * m[6]);
        t2 = m[2] * (m[3] * m[7] - m[4] * m[6]);
        return t0 - t1 + t2;
    endfunction

    // Scale, round half away from zero, clamp to 48 bits
    function automatic logic [COEF_W-1:0] scaled_coef(input wide_t num, input wide_t den,
                                                      input wide_t scale, inout bit sat);
        wide_t n, an, ad, q, limit;
        bit    neg;
        n     = num * scale;
        neg   = (n < 0) != (den < 0);
        an    = (n < 0) ? -n : n;
        ad    = (den < 0) ? -den : den;
        q     = (2 * an + ad) / (2 * ad);
        limit = neg ? (wide_t'(1) <<< 47) : ((wide_t'(1) <<< 47) - 1);
        if (q > limit)
        begin
            sat = 1;
            q   = limit;
        end
        return neg ? -q[COEF_W-1:0] : q[COEF_W-1:0];
    endfunction

    function automatic fit_result_t solve_fit();
        fit_result_t res;
        wide_t       m [9];
        wide_t       t [9];
        wide_t       rhs [2][3];
        wide_t       den;
        bit          sat;
        res.coefs  = '0;
        res.status = FIT_OK;
        sat        = 0;
        if (run_points < MIN_POINTS)
        begin
            res.status = FIT_FEW;
            return res;
        end
        m[0] = sum_xx; m[1] = sum_xy; m[2] = sum_x;
        m[3] = sum_xy; m[4] = sum_yy; m[5] = sum_y;
        m[6] = sum_x;  m[7] = sum_y;  m[8] = wide_t'(run_points);
        den = det3(m);
        if (den == 0)
        begin
            res.status = FIT_SINGULAR;
            return res;
        end
        rhs[0][0] = sum_txx; rhs[0][1] = sum_txy; rhs[0][2] = sum_tx;
        rhs[1][0] = sum_tyx; rhs[1][1] = sum_tyy; rhs[1][2] = sum_ty;
        // Cramer's rule: replace one column per coefficient
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t = m;
                t[c]     = rhs[r][0];
                t[3 + c] = rhs[r][1];
                t[6 + c] = rhs[r][2];
                res.coefs[(3 * r + c) * COEF_W +: COEF_W] =
                    scaled_coef(det3(t), den, (c == 2) ? 256 : 65536, sat);
            end
        end
        res.status = (sat || points_dropped) ? FIT_OVERFLOW : FIT_OK;
        return res;
    endfunction

    // Accumulate every accepted point, predict a fit at each run end, compare every accepted fit
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [63:0] sx, sy, tx, ty;
        fit_result_t        want;
        if (!rst_n)
        begin
            clear_sums();
            fit_queue.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                sx = 64'($signed(s_tdata[0 * IN_W +: IN_W]));
                sy = 64'($signed(s_tdata[1 * IN_W +: IN_W]));
                tx = 64'($signed(s_tdata[2 * IN_W +: IN_W]));
                ty = 64'($signed(s_tdata[3 * IN_W +: IN_W]));
                if (run_points < MAX_POINTS)
                begin
                    sum_xx  += sx * sx;  sum_xy  += sx * sy;  sum_yy += sy * sy;
                    sum_x   += sx;       sum_y   += sy;
                    sum_txx += tx * sx;  sum_txy += tx * sy;  sum_tx += tx;
                    sum_tyx += ty * sx;  sum_tyy += ty * sy;  sum_ty += ty;
                    run_points++;
                end
                else
                    points_dropped = 1;
                if (s_tlast)
                begin
                    fit_queue.push_back(solve_fit());
                    clear_sums();
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (fit_queue.size() == 0)
                    report("unexpected fit", {62'd0, m_tuser}, 64'd0);
                else
                begin
                    want = fit_queue.pop_front();
                    for (int k = 0; k < NUM_COEF; k++)
                        if (m_tdata[k * COEF_W +: COEF_W] !== want.coefs[k * COEF_W +: COEF_W])
                            report($sformatf("coef %0d", k),
                                   64'(m_tdata[k * COEF_W +: COEF_W]),
                                   64'(want.coefs[k * COEF_W +: COEF_W]));
                    if (m_tuser !== want.status)
                        report("fit_status", 64'(m_tuser), 64'(want.status));
                end
            end
        end
    end

endmodule

[sim/affine_least_squares_fit_unit_tb.sv]
`timescale 1ns / 1ps

module affine_least_squares_fit_unit_tb;
    import alsf_pkg::*;

    localparam int  MAX_PTS     = 4096;
    localparam int  POINT_GOAL  = 1750;
    localparam int  QUIET_AFTER = 1550;
    localparam int  SOLVE_CYC   = 3543;
    localparam longint CYCLE_LIMIT = 6000000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;

    int     mismatches;
    int     fits_pending;
    int     points_sent;
    int     runs_sent;
    bit     quiet;
    bit     run_gaps;
    int     stall_left;
    longint cycles;

    affine_least_squares_fit_unit #(.MAX_POINTS(MAX_PTS)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    affine_least_squares_fit_checker #(.MAX_POINTS(MAX_PTS)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .fits_pending (fits_pending)
    );

    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Guard against a hung run
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result-side backpressure in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 0;
            stall_left <= 0;
        end
        else if (quiet)
            m_tready <= 1;
        else if (stall_left > 0)
        begin
            m_tready   <= 0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            m_tready   <= 0;
            stall_left <= $urandom_range(0, 14);
        end
        else
            m_tready <= 1;
    end

    // Offer one point and hold it until the transaction completes
    task automatic send_point(input logic [IN_W-1:0] sx, input logic [IN_W-1:0] sy,
                              input logic [IN_W-1:0] tx, input logic [IN_W-1:0] ty,
                              input logic last);
        if (!quiet && run_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {ty, tx, sy, sx};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        points_sent++;
        if (last)
            runs_sent++;
    endtask

    task automatic idle_sender();
        s_tvalid <= 0;
        s_tlast  <= 0;
        @(posedge clk);
    endtask

    function automatic logic [IN_W-1:0] pick_value(input int mode);
        case (mode)
            0:       return IN_W'($urandom);
            1:       return IN_W'($signed($urandom_range(0, 2000)) - 1000);
            default: return IN_W'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // One run of random content; some runs are near-affine or degenerate
    task automatic random_run(input int len);
        int                 mode;
        int                 shape;
        logic signed [31:0] ka, kb, kd, ke, sx, sy;
        mode  = $urandom_range(0, 2);
        shape = $urandom_range(0, 9);
        ka = $signed($urandom_range(0, 64)) - 32;
        kb = $signed($urandom_range(0, 64)) - 32;
        kd = $signed($urandom_range(0, 64)) - 32;
        ke = $signed($urandom_range(0, 64)) - 32;
        run_gaps = $urandom_range(0, 3) != 0;
        for (int i = 0; i < len; i++)
        begin
            sx = 32'($signed(pick_value(mode)));
            sy = 32'($signed(pick_value(mode)));
            if (shape == 0)
                sy = sx;
            else if (shape == 1)
                sx = 32'sd77;
            if (shape >= 6)
                send_point(IN_W'(sx), IN_W'(sy),
                           IN_W'(((ka * sx + kb * sy) >>> 4) + $signed($urandom_range(0, 4))),
                           IN_W'(((kd * sx + ke * sy) >>> 4) - $signed($urandom_range(0, 4))),
                           i == len - 1);
            else
                send_point(IN_W'(sx), IN_W'(sy), pick_value(mode), pick_value(mode),
                           i == len - 1);
        end
    endtask

    initial
    begin
        int len;
        s_tvalid    = 0;
        s_tdata     = '0;
        s_tlast     = 0;
        rst_n       = 0;
        quiet       = 0;
        run_gaps    = 1;
        points_sent = 0;
        runs_sent   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Short runs of one and two points, field extremes
        send_point(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 1);
        send_point(24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 0);
        send_point(24'hffffff, 24'h000000, 24'h000000, 24'hffffff, 1);
        // Exact affine fit on three points
        send_point(24'd0,   24'd0,   24'd10,  24'd20,  0);
        send_point(24'd256, 24'd0,   24'd522, 24'd20,  0);
        send_point(24'd0,   24'd256, 24'd10,  24'd788, 1);
        // Singular: repeated point, then collinear points
        repeat (2) send_point(24'd300, 24'd400, 24'd5, 24'd6, 0);
        send_point(24'd300, 24'd400, 24'd5, 24'd6, 1);
        send_point(24'd1, 24'd1, 24'd9, 24'd3, 0);
        send_point(24'd2, 24'd2, 24'd8, 24'd2, 0);
        send_point(24'd3, 24'd3, 24'd7, 24'd1, 1);
        // Saturating offset: near-vertical step far from the origin
        send_point(24'd8388600, 24'd0, 24'h800000, 24'd0, 0);
        send_point(24'd8388601, 24'd0, 24'h7fffff, 24'd0, 0);
        send_point(24'd8388600, 24'd1, 24'h800000, 24'd0, 1);
        // Extremes on every field in a four-point run
        send_point(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 0);
        send_point(24'h800000, 24'h800000, 24'h800000, 24'h800000, 0);
        send_point(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, 0);
        send_point(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 1);

        // Hold off until every fit so far has come back
        idle_sender();
        while (fits_pending != 0) @(posedge clk);

        // Random runs, mostly short and well formed
        while (points_sent < POINT_GOAL)
        begin
            if (points_sent > QUIET_AFTER)
                quiet = 1;
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(1, 2);
                1:       len = $urandom_range(17, 60);
                default: len = $urandom_range(3, 16);
            endcase
            random_run(len);
        end

        idle_sender();
        while (fits_pending != 0) @(posedge clk);
        repeat (SOLVE_CYC / 10) @(posedge clk);

        $display("covered %0d runs: short, singular, saturating and random fits",
                 runs_sent);
        $display("points sent across directed and random runs: %0d", points_sent);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[affine_least_squares_fit_unit.f]
src/alsf_pkg.sv
src/alsf_div.sv
src/alsf_dp.sv
src/alsf_ctrl.sv
src/affine_least_squares_fit_unit.sv
sim/affine_least_squares_fit_checker.sv
sim/affine_least_squares_fit_unit_tb.sv
